@@ src/udw_pkg.sv @@
// Shared types, constants and the width lookup for the UTF-8 display width unit.
// No dependencies.
package udw_pkg;

    localparam int SUM_BITS = 16;
    localparam int CP_BITS  = 21;
    localparam int OUT_BITS = 16;

    // Event passed from the decoder to the accumulator
    typedef enum logic [1:0] {
        EV_NONE,
        EV_CHAR,
        EV_ERR_UTF,
        EV_ERR_CTRL
    } ev_kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_UTF  = 2'd1,
        ST_CTRL = 2'd2
    } status_t;

    // Width class of one codepoint
    typedef enum logic [1:0] {
        COL_ZERO,
        COL_ONE,
        COL_TWO,
        COL_CTRL
    } col_t;

    typedef struct packed {
        ev_kind_t             kind;
        logic [CP_BITS-1:0]   cp;
        logic                 last;
    } ev_t;

    function automatic logic in_rng(input logic [CP_BITS-1:0] cp,
                                    input logic [CP_BITS-1:0] lo,
                                    input logic [CP_BITS-1:0] hi);
        in_rng = (cp >= lo) && (cp <= hi);
    endfunction

    // Combining and format characters that take no column
    function automatic logic is_zero_width(input logic [CP_BITS-1:0] cp);
        is_zero_width =
            in_rng(cp, 21'h0300, 21'h0357) || in_rng(cp, 21'h035D, 21'h036F) ||
            in_rng(cp, 21'h0483, 21'h0486) || in_rng(cp, 21'h0488, 21'h0489) ||
            in_rng(cp, 21'h0591, 21'h05A1) || in_rng(cp, 21'h05A3, 21'h05B9) ||
            in_rng(cp, 21'h05BB, 21'h05BD) || in_rng(cp, 21'h05BF, 21'h05BF) ||
            in_rng(cp, 21'h05C1, 21'h05C2) || in_rng(cp, 21'h05C4, 21'h05C4) ||
            in_rng(cp, 21'h0600, 21'h0603) || in_rng(cp, 21'h0610, 21'h0615) ||
            in_rng(cp, 21'h064B, 21'h0658) || in_rng(cp, 21'h0670, 21'h0670) ||
            in_rng(cp, 21'h06D6, 21'h06E4) || in_rng(cp, 21'h06E7, 21'h06E8) ||
            in_rng(cp, 21'h06EA, 21'h06ED) || in_rng(cp, 21'h070F, 21'h070F) ||
            in_rng(cp, 21'h0711, 21'h0711) || in_rng(cp, 21'h0730, 21'h074A) ||
            in_rng(cp, 21'h07A6, 21'h07B0) || in_rng(cp, 21'h0901, 21'h0902) ||
            in_rng(cp, 21'h093C, 21'h093C) || in_rng(cp, 21'h0941, 21'h0948) ||
            in_rng(cp, 21'h094D, 21'h094D) || in_rng(cp, 21'h0951, 21'h0954) ||
            in_rng(cp, 21'h0962, 21'h0963) || in_rng(cp, 21'h0981, 21'h0981) ||
            in_rng(cp, 21'h09BC, 21'h09BC) || in_rng(cp, 21'h09C1, 21'h09C4) ||
            in_rng(cp, 21'h09CD, 21'h09CD) || in_rng(cp, 21'h09E2, 21'h09E3) ||
            in_rng(cp, 21'h0A01, 21'h0A02) || in_rng(cp, 21'h0A3C, 21'h0A3C) ||
            in_rng(cp, 21'h0A41, 21'h0A42) || in_rng(cp, 21'h0A47, 21'h0A48) ||
            in_rng(cp, 21'h0A4B, 21'h0A4D) || in_rng(cp, 21'h0A70, 21'h0A71) ||
            in_rng(cp, 21'h0A81, 21'h0A82) || in_rng(cp, 21'h0ABC, 21'h0ABC) ||
            in_rng(cp, 21'h0AC1, 21'h0AC5) || in_rng(cp, 21'h0AC7, 21'h0AC8) ||
            in_rng(cp, 21'h0ACD, 21'h0ACD) || in_rng(cp, 21'h0AE2, 21'h0AE3) ||
            in_rng(cp, 21'h0B01, 21'h0B01) || in_rng(cp, 21'h0B3C, 21'h0B3C) ||
            in_rng(cp, 21'h0B3F, 21'h0B3F) || in_rng(cp, 21'h0B41, 21'h0B43) ||
            in_rng(cp, 21'h0B4D, 21'h0B4D) || in_rng(cp, 21'h0B56, 21'h0B56) ||
            in_rng(cp, 21'h0B82, 21'h0B82) || in_rng(cp, 21'h0BC0, 21'h0BC0) ||
            in_rng(cp, 21'h0BCD, 21'h0BCD) || in_rng(cp, 21'h0C3E, 21'h0C40) ||
            in_rng(cp, 21'h0C46, 21'h0C48) || in_rng(cp, 21'h0C4A, 21'h0C4D) ||
            in_rng(cp, 21'h0C55, 21'h0C56) || in_rng(cp, 21'h0CBC, 21'h0CBC) ||
            in_rng(cp, 21'h0CBF, 21'h0CBF) || in_rng(cp, 21'h0CC6, 21'h0CC6) ||
            in_rng(cp, 21'h0CCC, 21'h0CCD) || in_rng(cp, 21'h0D41, 21'h0D43) ||
            in_rng(cp, 21'h0D4D, 21'h0D4D) || in_rng(cp, 21'h0DCA, 21'h0DCA) ||
            in_rng(cp, 21'h0DD2, 21'h0DD4) || in_rng(cp, 21'h0DD6, 21'h0DD6) ||
            in_rng(cp, 21'h0E31, 21'h0E31) || in_rng(cp, 21'h0E34, 21'h0E3A) ||
            in_rng(cp, 21'h0E47, 21'h0E4E) || in_rng(cp, 21'h0EB1, 21'h0EB1) ||
            in_rng(cp, 21'h0EB4, 21'h0EB9) || in_rng(cp, 21'h0EBB, 21'h0EBC) ||
            in_rng(cp, 21'h0EC8, 21'h0ECD) || in_rng(cp, 21'h0F18, 21'h0F19) ||
            in_rng(cp, 21'h0F35, 21'h0F35) || in_rng(cp, 21'h0F37, 21'h0F37) ||
            in_rng(cp, 21'h0F39, 21'h0F39) || in_rng(cp, 21'h0F71, 21'h0F7E) ||
            in_rng(cp, 21'h0F80, 21'h0F84) || in_rng(cp, 21'h0F86, 21'h0F87) ||
            in_rng(cp, 21'h0F90, 21'h0F97) || in_rng(cp, 21'h0F99, 21'h0FBC) ||
            in_rng(cp, 21'h0FC6, 21'h0FC6) || in_rng(cp, 21'h102D, 21'h1030) ||
            in_rng(cp, 21'h1032, 21'h1032) || in_rng(cp, 21'h1036, 21'h1037) ||
            in_rng(cp, 21'h1039, 21'h1039) || in_rng(cp, 21'h1058, 21'h1059) ||
            in_rng(cp, 21'h1160, 21'h11FF) || in_rng(cp, 21'h1712, 21'h1714) ||
            in_rng(cp, 21'h1732, 21'h1734) || in_rng(cp, 21'h1752, 21'h1753) ||
            in_rng(cp, 21'h1772, 21'h1773) || in_rng(cp, 21'h17B4, 21'h17B5) ||
            in_rng(cp, 21'h17B7, 21'h17BD) || in_rng(cp, 21'h17C6, 21'h17C6) ||
            in_rng(cp, 21'h17C9, 21'h17D3) || in_rng(cp, 21'h17DD, 21'h17DD) ||
            in_rng(cp, 21'h180B, 21'h180D) || in_rng(cp, 21'h18A9, 21'h18A9) ||
            in_rng(cp, 21'h1920, 21'h1922) || in_rng(cp, 21'h1927, 21'h1928) ||
            in_rng(cp, 21'h1932, 21'h1932) || in_rng(cp, 21'h1939, 21'h193B) ||
            in_rng(cp, 21'h200B, 21'h200F) || in_rng(cp, 21'h202A, 21'h202E) ||
            in_rng(cp, 21'h2060, 21'h2063) || in_rng(cp, 21'h206A, 21'h206F) ||
            in_rng(cp, 21'h20D0, 21'h20EA) || in_rng(cp, 21'h302A, 21'h302F) ||
            in_rng(cp, 21'h3099, 21'h309A) || in_rng(cp, 21'hFB1E, 21'hFB1E) ||
            in_rng(cp, 21'hFE00, 21'hFE0F) || in_rng(cp, 21'hFE20, 21'hFE23) ||
            in_rng(cp, 21'hFEFF, 21'hFEFF) || in_rng(cp, 21'hFFF9, 21'hFFFB) ||
            in_rng(cp, 21'h1D167, 21'h1D169) || in_rng(cp, 21'h1D173, 21'h1D182) ||
            in_rng(cp, 21'h1D185, 21'h1D18B) || in_rng(cp, 21'h1D1AA, 21'h1D1AD) ||
            in_rng(cp, 21'hE0001, 21'hE0001) || in_rng(cp, 21'hE0020, 21'hE007F) ||
            in_rng(cp, 21'hE0100, 21'hE01EF);
    endfunction

    // East Asian wide and fullwidth ranges
    function automatic logic is_wide(input logic [CP_BITS-1:0] cp);
        is_wide = in_rng(cp, 21'h1100, 21'h115F) ||
                  cp == 21'h2329 || cp == 21'h232A ||
                  (in_rng(cp, 21'h2E80, 21'hA4CF) && cp != 21'h303F) ||
                  in_rng(cp, 21'hAC00, 21'hD7A3) || in_rng(cp, 21'hF900, 21'hFAFF) ||
                  in_rng(cp, 21'hFE10, 21'hFE19) || in_rng(cp, 21'hFE30, 21'hFE6F) ||
                  in_rng(cp, 21'hFF00, 21'hFF60) || in_rng(cp, 21'hFFE0, 21'hFFE6) ||
                  in_rng(cp, 21'h20000, 21'h2FFFD) || in_rng(cp, 21'h30000, 21'h3FFFD);
    endfunction

    function automatic col_t cp_columns(input logic [CP_BITS-1:0] cp);
        if (cp < 21'h20 || in_rng(cp, 21'h7F, 21'h9F)) begin
            cp_columns = COL_CTRL;
        end else if (is_zero_width(cp)) begin
            cp_columns = COL_ZERO;
        end else if (is_wide(cp)) begin
            cp_columns = COL_TWO;
        end else begin
            cp_columns = COL_ONE;
        end
    endfunction

endpackage

@@ src/udw_front.sv @@
// UTF-8 decoder front end: validates bytes and emits one event per byte.
// Depends on udw_pkg.
module udw_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                in_ready,
    output udw_pkg::ev_t        ev_out,
    output logic                ev_valid,
    input  logic                ev_ready
);
    import udw_pkg::*;

    logic [1:0]         pend_reg, pend_next;
    logic [7:0]         lead_reg, lead_next;
    logic [CP_BITS-1:0] part_reg, part_next;
    logic               stop_reg, stop_next;
    logic               start_reg, start_next;
    logic               accept;
    logic               bad_cont;
    ev_t                ev;

    assign in_ready = ev_ready;
    assign ev_valid = in_valid;
    assign accept   = in_valid && ev_ready;
    assign ev_out   = ev;

    // Continuation byte checks, including overlong, surrogate and range limits
    assign bad_cont = (in_byte[7:6] != 2'b10) ||
                      (lead_reg == 8'hE0 && pend_reg == 2'd2 && in_byte < 8'hA0) ||
                      (lead_reg == 8'hED && pend_reg == 2'd2 && in_byte >= 8'hA0) ||
                      (lead_reg == 8'hF0 && pend_reg == 2'd3 && in_byte < 8'h90) ||
                      (lead_reg == 8'hF4 && pend_reg == 2'd3 && in_byte >= 8'h90);

    // Decode one byte
    always_comb begin
        pend_next  = pend_reg;
        lead_next  = lead_reg;
        part_next  = part_reg;
        stop_next  = stop_reg;
        start_next = start_reg;
        ev.kind    = EV_NONE;
        ev.cp      = {{(CP_BITS-8){1'b0}}, in_byte};
        ev.last    = in_last;
        if (!stop_reg) begin
            if (pend_reg == 2'd0) begin
                start_next = 1'b0;
                lead_next  = in_byte;
                priority if (in_byte == 8'h00) begin
                    stop_next = 1'b1;
                    if (start_reg) begin
                        ev.kind = EV_ERR_CTRL;
                    end
                end else if (in_byte < 8'h80) begin
                    ev.kind = EV_CHAR;
                end else if (in_byte < 8'hC2 || in_byte > 8'hF4) begin
                    ev.kind   = EV_ERR_UTF;
                    stop_next = 1'b1;
                end else if (in_byte < 8'hE0) begin
                    pend_next = 2'd1;
                    part_next = {{(CP_BITS-5){1'b0}}, in_byte[4:0]};
                end else if (in_byte < 8'hF0) begin
                    pend_next = 2'd2;
                    part_next = {{(CP_BITS-4){1'b0}}, in_byte[3:0]};
                end else begin
                    pend_next = 2'd3;
                    part_next = {{(CP_BITS-3){1'b0}}, in_byte[2:0]};
                end
            end else if (bad_cont) begin
                ev.kind   = EV_ERR_UTF;
                stop_next = 1'b1;
            end else begin
                part_next = {part_reg[CP_BITS-7:0], in_byte[5:0]};
                pend_next = pend_reg - 2'd1;
                if (pend_reg == 2'd1) begin
                    ev.kind = EV_CHAR;
                    ev.cp   = part_next;
                end
            end
        end
        // Flag a truncated character at the end of the string
        if (in_last && !stop_next && pend_next != 2'd0) begin
            ev.kind = EV_ERR_UTF;
        end
        if (in_last) begin
            pend_next  = 2'd0;
            lead_next  = 8'h00;
            part_next  = '0;
            stop_next  = 1'b0;
            start_next = 1'b1;
        end
    end

    // Advance decoder state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= 2'd0;
            lead_reg  <= 8'h00;
            part_reg  <= '0;
            stop_reg  <= 1'b0;
            start_reg <= 1'b1;
        end else if (accept) begin
            pend_reg  <= pend_next;
            lead_reg  <= lead_next;
            part_reg  <= part_next;
            stop_reg  <= stop_next;
            start_reg <= start_next;
        end
    end

endmodule

@@ src/udw_fifo.sv @@
// Two-entry event queue between the decoder and the accumulator.
// Depends on udw_pkg.
module udw_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  udw_pkg::ev_t  wr_data,
    input  logic          wr_valid,
    output logic          wr_ready,
    output udw_pkg::ev_t  rd_data,
    output logic          rd_valid,
    input  logic          rd_ready
);
    import udw_pkg::*;

    ev_t        mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    // Hold entries and move pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

@@ src/udw_back.sv @@
// Accumulator back end: classifies codepoint width, sums, and registers the result.
// Depends on udw_pkg.
module udw_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  udw_pkg::ev_t                ev_in,
    input  logic                        ev_valid,
    output logic                        ev_ready,
    output logic [udw_pkg::OUT_BITS-1:0] total_width,
    output logic [1:0]                  status,
    output logic                        res_valid,
    input  logic                        res_ready
);
    import udw_pkg::*;

    logic [SUM_BITS-1:0] sum_reg, sum_next;
    status_t             err_reg, err_next;
    logic                out_valid_reg;
    logic [OUT_BITS-1:0] out_width_reg;
    status_t             out_status_reg;
    logic                take;
    col_t                col;
    logic [SUM_BITS:0]   sum_add;
    logic [1:0]          col_add;

    assign ev_ready    = !ev_in.last || !out_valid_reg || res_ready;
    assign take        = ev_valid && ev_ready;
    assign col         = cp_columns(ev_in.cp);
    assign col_add     = (col == COL_TWO) ? 2'd2 : ((col == COL_ONE) ? 2'd1 : 2'd0);
    assign sum_add     = {1'b0, sum_reg} + {{(SUM_BITS-1){1'b0}}, col_add};
    assign total_width = out_width_reg;
    assign status      = out_status_reg;
    assign res_valid   = out_valid_reg;

    // Apply one event; first error wins
    always_comb begin
        sum_next = sum_reg;
        err_next = err_reg;
        if (err_reg == ST_OK) begin
            unique case (ev_in.kind)
                EV_CHAR: begin
                    if (col == COL_CTRL) begin
                        err_next = ST_CTRL;
                    end else if (sum_add[SUM_BITS]) begin
                        sum_next = '1;
                    end else begin
                        sum_next = sum_add[SUM_BITS-1:0];
                    end
                end
                EV_ERR_UTF:  err_next = ST_UTF;
                EV_ERR_CTRL: err_next = ST_CTRL;
                default:     ;
            endcase
        end
    end

    // Update the running sum and error state, clear both at string end, and track result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            if (take && ev_in.last) begin
                out_valid_reg <= 1'b1;
            end else if (res_valid && res_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (take) begin
                if (ev_in.last) begin
                    sum_reg <= '0;
                    err_reg <= ST_OK;
                end else begin
                    sum_reg <= sum_next;
                    err_reg <= err_next;
                end
            end
        end
    end

    // Register the result payload
    always_ff @(posedge aclk) begin
        if (take && ev_in.last) begin
            out_status_reg <= err_next;
            if (err_next != ST_OK) begin
                out_width_reg <= '0;
            end else if ({{(32-SUM_BITS){1'b0}}, sum_next} > 32'(2**OUT_BITS - 1)) begin
                out_width_reg <= '1;
            end else begin
                out_width_reg <= OUT_BITS'(sum_next);
            end
        end
    end

endmodule

@@ src/utf8_string_display_width_unit.sv @@
// Result path: the last byte is registered in the queue, then in the result register (m_valid).
// Throughput: one byte per cycle while s_ready is high; the sum updates on each event taken.
// Stall: a waiting result holds back the next last byte; the two-entry queue then fills.
// Reset: aresetn synchronous active low clears decoder, queue and sum; next byte starts a string.
// Depends on udw_pkg, udw_front, udw_fifo, udw_back.
module utf8_string_display_width_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_total_width,
    output logic [1:0]  m_status
);
    import udw_pkg::*;

    ev_t  f_ev, q_ev;
    logic f_valid, f_ready, q_valid, q_ready;

    udw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_byte  (s_data_byte),
        .in_last  (s_last_byte),
        .in_ready (s_ready),
        .ev_out   (f_ev),
        .ev_valid (f_valid),
        .ev_ready (f_ready)
    );

    udw_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_data  (f_ev),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_data  (q_ev),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    udw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ev_in       (q_ev),
        .ev_valid    (q_valid),
        .ev_ready    (q_ready),
        .total_width (m_total_width),
        .status      (m_status),
        .res_valid   (m_valid),
        .res_ready   (m_ready)
    );

endmodule

@@ src/udw_checker.sv @@
// Port-level checks for the display width unit, bound to the top level.
// Depends on udw_pkg and utf8_string_display_width_unit.
module udw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_total_width,
    input logic [1:0]  m_status
);
    import udw_pkg::*;

    // No result right after reset
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Only defined status codes are produced
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_UTF || m_status == ST_CTRL))
        else $error("bad status code");

    // Error results carry zero width
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_total_width == 16'd0))
        else $error("nonzero width on error");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_total_width) && $stable(m_status)))
        else $error("stalled result changed");

endmodule

bind utf8_string_display_width_unit udw_checker u_udw_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_total_width (m_total_width),
    .m_status      (m_status)
);
